// ----- rtl/core/mmrle_pkg.sv -----
// ----------------------------------------------------------------------------
// mmrle_pkg
// Shared types and constants of the multi-method run-length decoder.
// ----------------------------------------------------------------------------
package mmrle_pkg;

   // decoder phase, one-hot
   typedef enum logic [6:0] {
      PH_METHOD = 7'b0000001,
      PH_FIRST  = 7'b0000010,
      PH_STREAM = 7'b0000100,
      PH_TKEY   = 7'b0001000,
      PH_TVAL   = 7'b0010000,
      PH_VALUE  = 7'b0100000,
      PH_COUNT  = 7'b1000000
   } phase_type;

   // methods
   localparam logic [2:0] M_COPY    = 3'd0;
   localparam logic [2:0] M_NIB_HI  = 3'd1;
   localparam logic [2:0] M_MARK_HI = 3'd2;
   localparam logic [2:0] M_NIB_LO  = 3'd3;
   localparam logic [2:0] M_MARK_LO = 3'd4;
   localparam logic [2:0] M_PAIR    = 3'd5;
   localparam logic [2:0] M_BTAB    = 3'd6;
   localparam logic [2:0] M_ESC     = 3'd7;

   localparam logic [7:0] TABLE_END = 8'hFF;

   // one run word
   typedef struct packed {
      logic [7:0] value;
      logic [8:0] count;
      logic       eoc;
   } run_type;

endpackage

// ----- rtl/core/mmrle_btab.sv -----
// ----------------------------------------------------------------------------
// mmrle_btab
// Byte-keyed table values: 256 x 8 synchronous memory, registered read.
// ----------------------------------------------------------------------------
module mmrle_btab (
   input  logic       clock,
   input  logic       wr_en,
   input  logic [7:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic       rd_en,
   input  logic [7:0] rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] mem [256];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read until a new one is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/mmrle_ofifo.sv -----
// ----------------------------------------------------------------------------
// mmrle_ofifo
// Four-entry result queue; takes up to two run words per cycle, gives one.
// ----------------------------------------------------------------------------
module mmrle_ofifo (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_cnt,
   input  mmrle_pkg::run_type  push_d0,
   input  mmrle_pkg::run_type  push_d1,
   output logic                room_two,
   output logic [2:0]          fill,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mmrle_pkg::run_type  rsp_head
);

   mmrle_pkg::run_type slot_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign pop       = rsp_valid & rsp_ready;
   assign wr_ptr_in = wr_ptr_ff + push_cnt;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push_cnt} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_d0;
      end
      if (push_cnt == 2'd2) begin
         slot_ff[wr_ptr_ff + 2'd1] <= push_d1;
      end
   end

   assign room_two  = (count_ff <= 3'd2);
   assign fill      = count_ff;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_head  = slot_ff[rd_ptr_ff];

endmodule

// ----- rtl/core/multi_method_rle_decoder.sv -----
// ----------------------------------------------------------------------------
// multi_method_rle_decoder
// Run-length decoder with eight methods selected by the first chunk byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one chunk byte per word (req_data_byte) with
//   req_last_byte marking the final byte of the chunk. The first byte of a
//   chunk selects the method by its low three bits.
//   rsp_ channel carries runs: rsp_run_value repeated rsp_run_count times;
//   rsp_end_of_chunk marks the last run of a chunk (count 0 on a bare end).
//   Each input word yields zero, one or two runs.
// Throughput: one input word per cycle while req_ready is high. Runs pass a four-entry queue and
//   leave one per cycle; req_ready drops while fewer than two slots are free.
// Output: a run is registered in the queue when its word is accepted and
//   leaves on rsp_ behind any earlier runs. The byte-table value is read from a
//   registered synchronous memory at the key word, used by the following count word.
// Reset: synchronous, active high; the decoder waits for a method byte, the
//   queue empties and all table valid bits clear. Table valid bits clear
//   again on every method byte.
// Stall: when rsp_ready is low, runs collect in the queue and req_ready
//   falls once the queue cannot take two more.
// ----------------------------------------------------------------------------
module multi_method_rle_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_run_value,
   output logic [8:0] rsp_run_count,
   output logic       rsp_end_of_chunk
);

   mmrle_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  method_ff, method_in;
   logic [7:0]  mark_ff, mark_in;
   logic [7:0]  hbyte_ff, hbyte_in;
   logic        hvalid_ff, hvalid_in;
   logic [7:0]  hkey_ff, hkey_in;
   logic [15:0] ntv_ff, ntv_in;
   logic [7:0]  ntval_ff [16];
   logic        nt_wr;
   logic [3:0]  nt_idx_wr;
   logic        nclosed_ff, nclosed_in;
   logic [255:0] btv_ff, btv_in;

   logic        accept;
   logic        bt_wr, bt_rd;
   logic [7:0]  bt_rdata;
   logic        do_stream;
   logic [1:0]  k;
   mmrle_pkg::run_type res [2];
   logic [2:0]  q_fill;

   logic [7:0]  b;
   logic        last;
   logic [3:0]  s_idx;
   logic [8:0]  s_cnt;
   logic        hit;
   logic        key_ok;
   logic [3:0]  key_idx;

   assign accept = req_valid & req_ready;
   assign b      = req_data_byte;
   assign last   = req_last_byte;

   // --- decode of one word ---
   always_comb begin
      phase_in   = phase_ff;
      method_in  = method_ff;
      mark_in    = mark_ff;
      hbyte_in   = hbyte_ff;
      hvalid_in  = hvalid_ff;
      hkey_in    = hkey_ff;
      ntv_in     = ntv_ff;
      nclosed_in = nclosed_ff;
      btv_in     = btv_ff;
      nt_wr      = 1'b0;
      nt_idx_wr  = '0;
      bt_wr      = 1'b0;
      bt_rd      = 1'b0;
      do_stream  = 1'b0;
      k          = 2'd0;
      res[0]     = '0;
      res[1]     = '0;
      s_idx      = '0;
      s_cnt      = '0;
      hit        = 1'b0;
      key_ok     = 1'b0;
      key_idx    = '0;

      case (phase_ff)
         mmrle_pkg::PH_METHOD: begin
            method_in  = b[2:0];
            ntv_in     = '0;
            btv_in     = '0;
            nclosed_in = 1'b0;
            hvalid_in  = 1'b0;
            case (b[2:0])
               mmrle_pkg::M_NIB_HI, mmrle_pkg::M_NIB_LO, mmrle_pkg::M_BTAB:
                  phase_in = mmrle_pkg::PH_TKEY;
               mmrle_pkg::M_MARK_HI, mmrle_pkg::M_MARK_LO, mmrle_pkg::M_ESC:
                  phase_in = mmrle_pkg::PH_FIRST;
               default:
                  phase_in = mmrle_pkg::PH_STREAM;
            endcase
         end
         mmrle_pkg::PH_FIRST: begin
            mark_in  = b;
            phase_in = mmrle_pkg::PH_STREAM;
         end
         mmrle_pkg::PH_TKEY: begin
            if (method_ff == mmrle_pkg::M_BTAB) begin
               if (last) begin
                  phase_in  = mmrle_pkg::PH_STREAM;
                  do_stream = 1'b1;
               end else begin
                  hkey_in  = b;
                  phase_in = mmrle_pkg::PH_TVAL;
               end
            end else if (b == mmrle_pkg::TABLE_END) begin
               phase_in = mmrle_pkg::PH_STREAM;
            end else begin
               hkey_in  = b;
               phase_in = mmrle_pkg::PH_TVAL;
            end
         end
         mmrle_pkg::PH_TVAL: begin
            if (method_ff == mmrle_pkg::M_BTAB) begin
               if (hkey_ff == mmrle_pkg::TABLE_END && b == mmrle_pkg::TABLE_END) begin
                  phase_in = mmrle_pkg::PH_STREAM;
               end else begin
                  bt_wr           = 1'b1;
                  btv_in[hkey_ff] = 1'b1;
                  phase_in        = mmrle_pkg::PH_TKEY;
               end
            end else if (b == mmrle_pkg::TABLE_END) begin
               phase_in = mmrle_pkg::PH_STREAM;
            end else begin
               phase_in = mmrle_pkg::PH_TKEY;
               if (method_ff == mmrle_pkg::M_NIB_HI) begin
                  key_ok  = (hkey_ff[3:0] == 4'h0);
                  key_idx = hkey_ff[7:4];
               end else begin
                  key_ok  = (hkey_ff[7:4] == 4'h0);
                  key_idx = hkey_ff[3:0];
               end
               if (!nclosed_ff) begin
                  if (!key_ok) begin
                     nclosed_in = 1'b1;
                  end else if (!ntv_ff[key_idx]) begin
                     // first entry wins
                     ntv_in[key_idx] = 1'b1;
                     nt_wr           = 1'b1;
                     nt_idx_wr       = key_idx;
                  end
               end
            end
         end
         mmrle_pkg::PH_VALUE: begin
            if (method_ff == mmrle_pkg::M_ESC) begin
               hbyte_in = b;
               phase_in = mmrle_pkg::PH_COUNT;
            end else begin
               res[0].value = b;
               if (method_ff == mmrle_pkg::M_MARK_HI) begin
                  res[0].count = {5'd0, hbyte_ff[3:0]} + 9'd3;
               end else begin
                  res[0].count = {5'd0, hbyte_ff[7:4]} + 9'd3;
               end
               k        = 2'd1;
               phase_in = mmrle_pkg::PH_STREAM;
            end
         end
         mmrle_pkg::PH_COUNT: begin
            if (method_ff == mmrle_pkg::M_ESC) begin
               res[0].value = hbyte_ff;
               res[0].count = {1'b0, b} + 9'd3;
            end else if (method_ff == mmrle_pkg::M_BTAB) begin
               res[0].value = bt_rdata;
               res[0].count = {1'b0, b} + 9'd2;
            end else begin
               res[0].value = hbyte_ff;
               res[0].count = {1'b0, b} + 9'd2;
               hvalid_in    = 1'b0;
            end
            k        = 2'd1;
            phase_in = mmrle_pkg::PH_STREAM;
         end
         default: begin
            do_stream = 1'b1;
         end
      endcase

      // stream byte of the current method
      if (do_stream) begin
         case (method_ff)
            mmrle_pkg::M_NIB_HI, mmrle_pkg::M_NIB_LO: begin
               if (method_ff == mmrle_pkg::M_NIB_HI) begin
                  s_idx = b[7:4];
                  s_cnt = {5'd0, b[3:0]} + 9'd2;
               end else begin
                  s_idx = b[3:0];
                  s_cnt = {5'd0, b[7:4]} + 9'd2;
               end
               if (ntv_ff[s_idx]) begin
                  res[0].value = ntval_ff[s_idx];
                  res[0].count = s_cnt;
               end else begin
                  res[0].value = b;
                  res[0].count = 9'd1;
               end
               k = 2'd1;
            end
            mmrle_pkg::M_MARK_HI, mmrle_pkg::M_MARK_LO: begin
               if (method_ff == mmrle_pkg::M_MARK_HI) begin
                  hit = ({b[7:4], 4'h0} == mark_ff);
               end else begin
                  hit = ({4'h0, b[3:0]} == mark_ff);
               end
               if (hit) begin
                  hbyte_in = b;
                  phase_in = mmrle_pkg::PH_VALUE;
               end else begin
                  res[0].value = b;
                  res[0].count = 9'd1;
                  k            = 2'd1;
               end
            end
            mmrle_pkg::M_PAIR: begin
               if (!hvalid_ff) begin
                  hbyte_in  = b;
                  hvalid_in = 1'b1;
               end else if (b == hbyte_ff) begin
                  phase_in = mmrle_pkg::PH_COUNT;
               end else begin
                  res[0].value = hbyte_ff;
                  res[0].count = 9'd1;
                  k            = 2'd1;
                  hbyte_in     = b;
               end
            end
            mmrle_pkg::M_BTAB: begin
               if (btv_ff[b]) begin
                  // fetch the value now; the count word uses it
                  hkey_in  = b;
                  bt_rd    = 1'b1;
                  phase_in = mmrle_pkg::PH_COUNT;
               end else begin
                  res[0].value = b;
                  res[0].count = 9'd1;
                  k            = 2'd1;
               end
            end
            mmrle_pkg::M_ESC: begin
               if (b == mark_ff) begin
                  phase_in = mmrle_pkg::PH_VALUE;
               end else begin
                  res[0].value = b;
                  res[0].count = 9'd1;
                  k            = 2'd1;
               end
            end
            default: begin
               res[0].value = b;
               res[0].count = 9'd1;
               k            = 2'd1;
            end
         endcase
      end

      // chunk end: flush a lone pair byte, then mark the last run
      if (last) begin
         if (method_in == mmrle_pkg::M_PAIR && hvalid_in &&
             phase_in != mmrle_pkg::PH_METHOD) begin
            res[k[0]].value = hbyte_in;
            res[k[0]].count = 9'd1;
            k               = k + 2'd1;
         end
         if (k == 2'd0) begin
            res[0] = '0;
            k      = 2'd1;
         end
         res[k[0] ^ 1'b1].eoc = 1'b1;
         phase_in  = mmrle_pkg::PH_METHOD;
         hvalid_in = 1'b0;
      end
   end

   // --- state registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mmrle_pkg::PH_METHOD;
         method_ff  <= '0;
         mark_ff    <= '0;
         hbyte_ff   <= '0;
         hvalid_ff  <= 1'b0;
         hkey_ff    <= '0;
         ntv_ff     <= '0;
         nclosed_ff <= 1'b0;
         btv_ff     <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         method_ff  <= method_in;
         mark_ff    <= mark_in;
         hbyte_ff   <= hbyte_in;
         hvalid_ff  <= hvalid_in;
         hkey_ff    <= hkey_in;
         ntv_ff     <= ntv_in;
         nclosed_ff <= nclosed_in;
         btv_ff     <= btv_in;
      end
   end

   // nibble table values, no reset
   always_ff @(posedge clock) begin
      if (accept && nt_wr) begin
         ntval_ff[nt_idx_wr] <= b;
      end
   end

   mmrle_btab u_btab (
      .clock   (clock),
      .wr_en   (accept & bt_wr),
      .wr_addr (hkey_ff),
      .wr_data (b),
      .rd_en   (accept & bt_rd),
      .rd_addr (b),
      .rd_data (bt_rdata)
   );

   mmrle_pkg::run_type head;

   mmrle_ofifo u_ofifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (accept ? k : 2'd0),
      .push_d0   (res[0]),
      .push_d1   (res[1]),
      .room_two  (req_ready),
      .fill      (q_fill),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_head  (head)
   );

   assign rsp_run_value    = head.value;
   assign rsp_run_count    = head.count;
   assign rsp_end_of_chunk = head.eoc;

   // --- checks ---
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      q_fill <= 3'd4)
      else $error("result queue overfilled");

   a_last_gives_run: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |-> (k != 2'd0))
      else $error("chunk end produced no run");

   a_method_leaves: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == mmrle_pkg::PH_METHOD && !req_last_byte)
      |=> (phase_ff != mmrle_pkg::PH_METHOD))
      else $error("method byte did not advance the decoder");

   a_last_to_method: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |=> (phase_ff == mmrle_pkg::PH_METHOD))
      else $error("decoder did not return to method phase after chunk end");

endmodule

// ----- test/multi_method_rle_decoder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_method_rle_decoder_checker
// Watches both channels, decodes every accepted byte itself and compares the
// runs that leave the decoder, word by word, with the runs it worked out.
// ----------------------------------------------------------------------------
module multi_method_rle_decoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_run_value,
   input  logic [8:0] rsp_run_count,
   input  logic       rsp_end_of_chunk,
   output int         fail_count,
   output int         runs_pending
);

   mmrle_pkg::phase_type phase;
   logic [2:0] method;
   logic [7:0] mark;
   logic [7:0] held;
   logic       held_ok;
   logic [7:0] key_held;
   logic [7:0] nib_val [16];
   logic       nib_ok [16];
   logic       nib_closed;
   logic [7:0] btab_val [256];
   logic       btab_ok [256];
   mmrle_pkg::run_type runs_due [$];
   mmrle_pkg::run_type fresh [$];

   function automatic mmrle_pkg::run_type mk_run(logic [7:0] v, logic [8:0] c);
      mmrle_pkg::run_type r;
      r.value = v;
      r.count = c;
      r.eoc   = 1'b0;
      return r;
   endfunction

   task automatic clear_tables();
      for (int i = 0; i < 16; i++) nib_ok[i] = 1'b0;
      for (int i = 0; i < 256; i++) btab_ok[i] = 1'b0;
      nib_closed = 1'b0;
      held_ok = 1'b0;
   endtask

   task automatic add_nibble_entry(logic [7:0] k, logic [7:0] v);
      logic [3:0] idx;
      logic       good;
      if (nib_closed) return;
      good = (method == mmrle_pkg::M_NIB_HI) ? (k[3:0] == 4'h0) : (k[7:4] == 4'h0);
      idx  = (method == mmrle_pkg::M_NIB_HI) ? k[7:4] : k[3:0];
      if (!good) begin
         nib_closed = 1'b1;
         return;
      end
      if (!nib_ok[idx]) begin
         nib_ok[idx] = 1'b1;
         nib_val[idx] = v;
      end
   endtask

   task automatic decode_stream_byte(logic [7:0] b);
      logic [3:0] idx;
      logic [8:0] cnt;
      case (method)
         mmrle_pkg::M_NIB_HI, mmrle_pkg::M_NIB_LO: begin
            idx = (method == mmrle_pkg::M_NIB_HI) ? b[7:4] : b[3:0];
            cnt = (method == mmrle_pkg::M_NIB_HI) ? b[3:0] + 9'd2 : b[7:4] + 9'd2;
            if (nib_ok[idx]) fresh.push_back(mk_run(nib_val[idx], cnt));
            else fresh.push_back(mk_run(b, 9'd1));
         end
         mmrle_pkg::M_MARK_HI, mmrle_pkg::M_MARK_LO: begin
            if ((method == mmrle_pkg::M_MARK_HI) ? ({b[7:4], 4'h0} == mark)
                                                 : ({4'h0, b[3:0]} == mark))
            begin
               held = b;
               phase = mmrle_pkg::PH_VALUE;
            end else fresh.push_back(mk_run(b, 9'd1));
         end
         mmrle_pkg::M_PAIR: begin
            if (!held_ok) begin
               held = b;
               held_ok = 1'b1;
            end else if (b == held) phase = mmrle_pkg::PH_COUNT;
            else begin
               fresh.push_back(mk_run(held, 9'd1));
               held = b;
            end
         end
         mmrle_pkg::M_BTAB: begin
            if (btab_ok[b]) begin
               key_held = b;
               phase = mmrle_pkg::PH_COUNT;
            end else fresh.push_back(mk_run(b, 9'd1));
         end
         mmrle_pkg::M_ESC: begin
            if (b == mark) phase = mmrle_pkg::PH_VALUE;
            else fresh.push_back(mk_run(b, 9'd1));
         end
         default: fresh.push_back(mk_run(b, 9'd1));
      endcase
   endtask

   // work out the runs that one accepted byte causes
   task automatic decode_byte(logic [7:0] b, logic last);
      mmrle_pkg::run_type r;
      fresh.delete();
      case (phase)
         mmrle_pkg::PH_METHOD: begin
            method = b[2:0];
            clear_tables();
            if (method inside {mmrle_pkg::M_NIB_HI, mmrle_pkg::M_NIB_LO, mmrle_pkg::M_BTAB})
               phase = mmrle_pkg::PH_TKEY;
            else if (method inside {mmrle_pkg::M_MARK_HI, mmrle_pkg::M_MARK_LO,
                                    mmrle_pkg::M_ESC})
               phase = mmrle_pkg::PH_FIRST;
            else phase = mmrle_pkg::PH_STREAM;
         end
         mmrle_pkg::PH_FIRST: begin
            mark = b;
            phase = mmrle_pkg::PH_STREAM;
         end
         mmrle_pkg::PH_TKEY: begin
            if (method == mmrle_pkg::M_BTAB) begin
               if (last) begin
                  phase = mmrle_pkg::PH_STREAM;
                  decode_stream_byte(b);
               end else begin
                  key_held = b;
                  phase = mmrle_pkg::PH_TVAL;
               end
            end else if (b == mmrle_pkg::TABLE_END) phase = mmrle_pkg::PH_STREAM;
            else begin
               key_held = b;
               phase = mmrle_pkg::PH_TVAL;
            end
         end
         mmrle_pkg::PH_TVAL: begin
            if (method == mmrle_pkg::M_BTAB) begin
               if (key_held == mmrle_pkg::TABLE_END && b == mmrle_pkg::TABLE_END)
                  phase = mmrle_pkg::PH_STREAM;
               else begin
                  btab_val[key_held] = b;
                  btab_ok[key_held] = 1'b1;
                  phase = mmrle_pkg::PH_TKEY;
               end
            end else if (b == mmrle_pkg::TABLE_END) phase = mmrle_pkg::PH_STREAM;
            else begin
               add_nibble_entry(key_held, b);
               phase = mmrle_pkg::PH_TKEY;
            end
         end
         mmrle_pkg::PH_VALUE: begin
            if (method == mmrle_pkg::M_ESC) begin
               held = b;
               phase = mmrle_pkg::PH_COUNT;
            end else begin
               fresh.push_back(mk_run(b, (method == mmrle_pkg::M_MARK_HI) ?
                  held[3:0] + 9'd3 : held[7:4] + 9'd3));
               phase = mmrle_pkg::PH_STREAM;
            end
         end
         mmrle_pkg::PH_COUNT: begin
            if (method == mmrle_pkg::M_ESC) fresh.push_back(mk_run(held, b + 9'd3));
            else if (method == mmrle_pkg::M_BTAB)
               fresh.push_back(mk_run(btab_val[key_held], b + 9'd2));
            else begin
               fresh.push_back(mk_run(held, b + 9'd2));
               held_ok = 1'b0;
            end
            phase = mmrle_pkg::PH_STREAM;
         end
         default: decode_stream_byte(b);
      endcase
      if (last) begin
         if (method == mmrle_pkg::M_PAIR && held_ok && phase != mmrle_pkg::PH_METHOD)
            fresh.push_back(mk_run(held, 9'd1));
         if (fresh.size() == 0) fresh.push_back(mk_run(8'h00, 9'd0));
         r = fresh[fresh.size() - 1];
         r.eoc = 1'b1;
         fresh[fresh.size() - 1] = r;
         phase = mmrle_pkg::PH_METHOD;
         held_ok = 1'b0;
      end
      foreach (fresh[i]) runs_due.push_back(fresh[i]);
   endtask

   always @(posedge clock) begin
      mmrle_pkg::run_type want;
      if (reset) begin
         phase = mmrle_pkg::PH_METHOD;
         method = mmrle_pkg::M_COPY;
         mark = 8'h00;
         held = 8'h00;
         key_held = 8'h00;
         clear_tables();
         runs_due.delete();
         fail_count = 0;
      end else begin
         // compare the leaving run before adding new ones: a run never leaves
         // in the cycle of the byte that makes it
         if (rsp_valid && rsp_ready) begin
            if (runs_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected run: value %02h count %0d end %0b",
                           rsp_run_value, rsp_run_count, rsp_end_of_chunk);
            end else begin
               want = runs_due.pop_front();
               if (rsp_run_value !== want.value || rsp_run_count !== want.count ||
                   rsp_end_of_chunk !== want.eoc) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("run mismatch: expected %02h/%0d/%0b got %02h/%0d/%0b",
                              want.value, want.count, want.eoc, rsp_run_value,
                              rsp_run_count, rsp_end_of_chunk);
               end
            end
         end
         if (req_valid && req_ready) decode_byte(req_data_byte, req_last_byte);
      end
      runs_pending = runs_due.size();
   end

endmodule

// ----- test/multi_method_rle_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_method_rle_decoder_tb
// Feeds chunks of every decoding method, well formed and broken, with random
// gaps and receiver stalls; the checker predicts and compares each run.
// ----------------------------------------------------------------------------
module multi_method_rle_decoder_tb;

   localparam int IDLE_LIMIT = 5000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_run_value;
   logic [8:0] rsp_run_count;
   logic       rsp_end_of_chunk;
   int         fail_count;
   int         runs_pending;
   int         bytes_sent;
   int         idle_cycles;
   bit         hold_off;
   bit         all_sent;
   logic [7:0] chunk [$];

   multi_method_rle_decoder uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_run_value(rsp_run_value), .rsp_run_count(rsp_run_count),
      .rsp_end_of_chunk(rsp_end_of_chunk)
   );

   multi_method_rle_decoder_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_run_value(rsp_run_value), .rsp_run_count(rsp_run_count),
      .rsp_end_of_chunk(rsp_end_of_chunk),
      .fail_count(fail_count), .runs_pending(runs_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // send one word: hold it until accepted, drop valid only when a gap
   // follows, so valid never falls and rises in one step
   task automatic send_word(logic [7:0] b, logic last, bit gap_after);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (gap_after) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   // send the queued chunk; bursts of random length separated by gaps
   task automatic send_chunk();
      int burst;
      burst = $urandom_range(1, 12);
      foreach (chunk[i]) begin
         burst--;
         send_word(chunk[i], i == chunk.size() - 1, burst == 0);
         if (burst == 0) burst = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 12);
      end
   endtask

   // random byte, often near the edges
   function automatic logic [7:0] any_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // build a chunk of the given method; broken ones cut it at a random point
   task automatic build_chunk(logic [2:0] m, bit broken);
      int n;
      logic [7:0] mk, k;
      chunk.delete();
      chunk.push_back({5'($urandom), m});
      n = $urandom_range(1, 10);
      case (m)
         mmrle_pkg::M_NIB_HI, mmrle_pkg::M_NIB_LO: begin
            repeat ($urandom_range(0, 5)) begin
               k = (m == mmrle_pkg::M_NIB_HI) ? {4'($urandom), 4'h0} : {4'h0, 4'($urandom)};
               if ($urandom_range(0, 9) == 0) k = any_byte();
               chunk.push_back(k);
               chunk.push_back(($urandom_range(0, 12) == 0) ? 8'hFF : 8'($urandom_range(0, 254)));
            end
            chunk.push_back(8'hFF);
            repeat (n) chunk.push_back(any_byte());
         end
         mmrle_pkg::M_MARK_HI, mmrle_pkg::M_MARK_LO, mmrle_pkg::M_ESC: begin
            if (m == mmrle_pkg::M_MARK_HI) mk = {4'($urandom), 4'h0};
            else if (m == mmrle_pkg::M_MARK_LO) mk = {4'h0, 4'($urandom)};
            else mk = any_byte();
            chunk.push_back(mk);
            repeat (n) begin
               if ($urandom_range(0, 1)) begin
                  if (m == mmrle_pkg::M_MARK_HI) chunk.push_back({mk[7:4], 4'($urandom)});
                  else if (m == mmrle_pkg::M_MARK_LO) chunk.push_back({4'($urandom), mk[3:0]});
                  else chunk.push_back(mk);
                  chunk.push_back(any_byte());
                  if (m == mmrle_pkg::M_ESC) chunk.push_back(any_byte());
               end else chunk.push_back(any_byte());
            end
         end
         mmrle_pkg::M_PAIR: repeat (n) begin
            k = any_byte();
            chunk.push_back(k);
            if ($urandom_range(0, 1)) begin
               chunk.push_back(k);
               chunk.push_back(any_byte());
            end
         end
         mmrle_pkg::M_BTAB: begin
            int nk;
            logic [7:0] keys [$];
            nk = $urandom_range(0, 5);
            repeat (nk) begin
               k = ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom);
               keys.push_back(k);
               chunk.push_back(k);
               chunk.push_back(($urandom_range(0, 3) == 0) ? 8'hFF : any_byte());
            end
            chunk.push_back(8'hFF);
            chunk.push_back(8'hFF);
            repeat (n) begin
               if (nk > 0 && $urandom_range(0, 1)) begin
                  chunk.push_back(keys[$urandom_range(0, nk - 1)]);
                  chunk.push_back(any_byte());
               end else chunk.push_back(any_byte());
            end
         end
         default: repeat (n) chunk.push_back(any_byte());
      endcase
      if (broken) begin
         n = $urandom_range(1, chunk.size());
         while (chunk.size() > n) void'(chunk.pop_back());
      end
   endtask

   // receiver: stall pattern of its own, plus one long hold-off
   initial begin
      int mode;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off) rsp_ready <= 1'b0;
         else begin
            mode = (bytes_sent / 150) % 3;
            if (mode == 0) rsp_ready <= 1'b1;
            else if (mode == 1) rsp_ready <= ($urandom_range(0, 3) != 0);
            else rsp_ready <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   initial begin
      wait (bytes_sent >= 400);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   // watchdog: stop when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
         idle_cycles <= 0;
      else if (!all_sent || runs_pending != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] d [$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      bytes_sent = 0;
      idle_cycles = 0;
      hold_off = 1'b0;
      all_sent = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: method byte alone, copy of extremes, truncated codes,
      // truncated pair, odd byte-table byte, 0xFF as table value, bad key,
      // duplicate keys
      d = '{8'hF8}; chunk = d; send_chunk();
      d = '{8'h00, 8'h00, 8'hFF}; chunk = d; send_chunk();
      d = '{8'h02, 8'h30, 8'h3F}; chunk = d; send_chunk();
      d = '{8'h07, 8'hAA, 8'h11, 8'hAA, 8'h55}; chunk = d; send_chunk();
      d = '{8'h05, 8'h42, 8'h42}; chunk = d; send_chunk();
      d = '{8'h05, 8'h42, 8'h42, 8'hFF, 8'h43}; chunk = d; send_chunk();
      d = '{8'h06, 8'h33}; chunk = d; send_chunk();
      d = '{8'h06, 8'h33, 8'h44, 8'h33, 8'h99, 8'hFF, 8'hFF, 8'h33, 8'hFF, 8'h33};
      chunk = d; send_chunk();
      d = '{8'h01, 8'h20, 8'h55, 8'h20, 8'h66, 8'h21, 8'h77, 8'h30, 8'h88, 8'hFF,
            8'h2F, 8'h3A};
      chunk = d; send_chunk();
      d = '{8'h03, 8'h05, 8'hFF, 8'h5F, 8'h05}; chunk = d; send_chunk();
      d = '{8'h04, 8'h0C, 8'hFC, 8'h9E, 8'h1C}; chunk = d; send_chunk();

      // random: mostly well-formed chunks of random content
      while (bytes_sent < 1200) begin
         build_chunk(3'($urandom), $urandom_range(0, 4) == 0);
         send_chunk();
      end
      @(negedge clock);
      req_valid <= 1'b0;
      all_sent = 1'b1;

      wait (runs_pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
